/* rtl/core/iat_pkg.sv */
// Package for the IPv4 alias table: sizes, function and status codes, helpers.
// No dependencies.
package iat_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int ALIAS_MAX_BYTES = 10;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_LOOKUP = 3'd1;
    localparam logic [2:0] FN_UPDATE = 3'd2;
    localparam logic [2:0] FN_DELETE = 3'd3;
    localparam logic [2:0] FN_LIST_LOC = 3'd4;
    localparam logic [2:0] FN_LIST_ALL = 3'd5;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_DUP_ADDR = 3'd2;
    localparam logic [2:0] ST_DUP_ALIAS = 3'd3;
    localparam logic [2:0] ST_BAD_ALIAS = 3'd4;
    localparam logic [2:0] ST_FULL = 3'd5;
    localparam logic [2:0] ST_EMPTY = 3'd6;

    typedef struct packed {
        logic [31:0] address;
        logic [79:0] alias_key;
    } entry_t;

    // per-cell match flags
    typedef struct packed {
        logic addr_eq;
        logic alias_eq;
        logic loc_eq;
    } match_t;

    function automatic logic [79:0] fold_alias(input logic [79:0] a);
        logic [79:0] r;
        r = a;
        for (int k = 0; k < 10; k++) begin
            if (a[k*8 +: 8] >= 8'h41 && a[k*8 +: 8] <= 8'h5a)
                r[k*8 +: 8] = a[k*8 +: 8] + 8'd32;
        end
        return r;
    endfunction
endpackage

/* rtl/core/ipv4_alias_table.sv */
// IPv4 alias table: a chain of cells, each holding one entry, compared in parallel.
// Single-result functions: the item is registered on acceptance, and the result is
// registered in the execute state once the output is free.
// Lists scan one valid entry per cycle while the output is free and hold each item until
// the next match or the end shows its last flag; when the final entry and an earlier one
// both match, a tail item is sent last. Input ready again once a single result is
// registered, or once the last list item is taken.
// Reset empties the table (count zero); entry contents are not reset.
// Depends on iat_pkg and iat_cell.
module ipv4_alias_table
    import iat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,  // address[31:0], alias_first[95:32], alias_rest[111:96]
    input  logic [2:0]   s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // address_res[31:0], alias_first_res[95:32],
                                        // alias_rest_res[111:96]
    output logic [2:0]   m_axis_tuser,  // status
    output logic         m_axis_tlast   // last
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [2:0] func_reg;
    entry_t key_reg;
    logic [79:0] key_fold_reg;
    logic bad_reg;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic found_reg, found_next;

    logic o_valid_reg;
    logic [2:0] o_status_reg;
    entry_t o_entry_reg;
    logic o_last_reg;

    // a pending item plus a final match leave one more to send
    logic tail_reg;
    entry_t tail_entry_reg;

    entry_t cell_entry [TABLE_DEPTH];
    match_t cell_match [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] sh_in, sh_out, ld_key, ld_addr, vld;

    // normalized key: zero bytes after the first zero, length and shape check
    logic [79:0] in_alias, norm_alias;
    logic in_bad;
    always_comb
    begin
        logic z;
        logic [3:0] len;
        in_alias = {s_axis_tdata[95:32], s_axis_tdata[111:96]};
        norm_alias = in_alias;
        z = 1'b0;
        len = 4'd10;
        in_bad = 1'b0;
        for (int k = 0; k < 10; k++) begin
            if (!z && in_alias[79-8*k -: 8] == 8'h00) begin
                z = 1'b1;
                len = 4'(k);
            end
            if (z)
                norm_alias[79-8*k -: 8] = 8'h00;
            else if (in_alias[79-8*k -: 8] == 8'h20 || in_alias[79-8*k -: 8] == 8'h09)
                in_bad = 1'b1;
        end
        if (len == 4'd0 || len > 4'(ALIAS_MAX_BYTES))
            in_bad = 1'b1;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        iat_cell u_cell (
            .clk       (clk),
            .shift_in  (sh_in[i]),
            .shift_out (sh_out[i]),
            .load_key  (ld_key[i]),
            .load_addr (ld_addr[i]),
            .prev_entry((i == 0) ? key_reg : cell_entry[(i == 0) ? 0 : i-1]),
            .next_entry(cell_entry[(i == TABLE_DEPTH-1) ? i : i+1]),
            .key_entry (key_reg),
            .key_fold  (key_fold_reg),
            .entry     (cell_entry[i]),
            .match     (cell_match[i])
        );
        assign vld[i] = (CNT_W'(i) < count_reg);
    end

    // first conflicting/matching cells, priority from the front
    logic [IDX_W-1:0] add_idx, hit_idx;
    logic add_hit, add_dup_addr, hit_any, addr_any;
    always_comb
    begin
        add_idx = '0; add_hit = 1'b0; add_dup_addr = 1'b0;
        hit_idx = '0; hit_any = 1'b0; addr_any = 1'b0;
        for (int i = TABLE_DEPTH-1; i >= 0; i--) begin
            if (vld[i] && (cell_match[i].addr_eq || cell_match[i].alias_eq)) begin
                add_hit = 1'b1; add_idx = IDX_W'(i);
                add_dup_addr = cell_match[i].addr_eq;
            end
            if (vld[i] && cell_match[i].alias_eq) begin
                hit_any = 1'b1; hit_idx = IDX_W'(i);
            end
            if (vld[i] && cell_match[i].addr_eq)
                addr_any = 1'b1;
        end
    end

    logic out_free;
    assign out_free = !o_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    logic loc_sel;
    logic scan_end;
    assign loc_sel = (func_reg == FN_LIST_ALL) || cell_match[scan_reg].loc_eq;
    assign scan_end = (CNT_W'(scan_reg) + CNT_W'(1) >= count_reg);

    logic e_valid, e_last;
    logic [2:0] e_status;
    entry_t e_entry;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next = scan_reg;
        found_next = found_reg;
        sh_in = '0; sh_out = '0; ld_key = '0; ld_addr = '0;
        e_valid = 1'b0; e_last = 1'b1; e_status = ST_OK; e_entry = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                scan_next = '0;
                found_next = 1'b0;
                if (out_free) begin
                    state_next = S_IDLE;
                    e_valid = 1'b1;
                    if (func_reg <= FN_DELETE && bad_reg)
                        e_status = ST_BAD_ALIAS;
                    else begin
                        case (func_reg)
                            FN_ADD:
                            begin
                                if (add_hit) begin
                                    e_status = add_dup_addr ? ST_DUP_ADDR : ST_DUP_ALIAS;
                                    e_entry = cell_entry[add_idx];
                                end else if (count_reg >= CNT_W'(TABLE_DEPTH))
                                    e_status = ST_FULL;
                                else begin
                                    e_entry = key_reg;
                                    ld_key[0] = 1'b1;
                                    sh_in = {{(TABLE_DEPTH-1){1'b1}}, 1'b0};
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            FN_LOOKUP, FN_UPDATE, FN_DELETE:
                            begin
                                if (!hit_any)
                                    e_status = ST_NOT_FOUND;
                                else begin
                                    e_entry = cell_entry[hit_idx];
                                    if (func_reg == FN_UPDATE) begin
                                        if (addr_any)
                                            e_status = ST_DUP_ADDR;
                                        else begin
                                            e_entry.address = key_reg.address;
                                            ld_addr[hit_idx] = 1'b1;
                                        end
                                    end else if (func_reg == FN_DELETE) begin
                                        for (int i = 0; i < TABLE_DEPTH-1; i++)
                                            sh_out[i] = (IDX_W'(i) >= hit_idx);
                                        count_next = count_reg - CNT_W'(1);
                                    end
                                end
                            end
                            FN_LIST_LOC, FN_LIST_ALL:
                            begin
                                e_valid = 1'b0;
                                if (count_reg == '0) begin
                                    e_valid = 1'b1;
                                    e_status = (func_reg == FN_LIST_ALL) ? ST_EMPTY
                                                                         : ST_NOT_FOUND;
                                end else
                                    state_next = S_LIST;
                            end
                            default: e_valid = 1'b0;
                        endcase
                    end
                end
            end
            S_LIST:
            begin
                if (out_free) begin
                    // one cell per cycle; an item goes out only when a later
                    // match (or the end) shows whether it is the last
                    if (loc_sel) begin
                        e_entry = cell_entry[scan_reg];
                    end
                    if (scan_end) begin
                        if (loc_sel) begin
                            e_valid = 1'b1;
                        end else if (!found_reg) begin
                            e_valid = 1'b1;
                            e_status = ST_NOT_FOUND;
                        end else begin
                            e_valid = 1'b0;
                        end
                        state_next = S_OUT;
                    end else begin
                        scan_next = scan_reg + IDX_W'(1);
                    end
                end
            end
            S_OUT:
            begin
                // with a tail item, leave only once the tail itself is taken
                if (tail_reg ? (!o_valid_reg && m_axis_tready) : out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // list path keeps one pending item so its last flag is known
    logic pend_reg;
    entry_t pend_entry_reg;
    logic list_take;
    assign list_take = (state_reg == S_LIST) && out_free && loc_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            o_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            scan_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg <= scan_next;
            found_reg <= found_next | list_take;
            if (state_reg == S_LIST && out_free) begin
                if (list_take) begin
                    pend_reg <= !scan_end;
                    o_valid_reg <= pend_reg || scan_end;
                end else if (scan_end) begin
                    pend_reg <= 1'b0;
                    o_valid_reg <= pend_reg || e_valid;
                end else begin
                    o_valid_reg <= 1'b0;
                end
            end else if (state_reg == S_OUT && out_free) begin
                o_valid_reg <= 1'b0;
            end else if (e_valid) begin
                o_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid) begin
            func_reg <= s_axis_tuser;
            key_reg.address <= s_axis_tdata[31:0];
            key_reg.alias_key <= norm_alias;
            key_fold_reg <= fold_alias(norm_alias);
            bad_reg <= in_bad;
        end
        if (state_reg == S_LIST && out_free) begin
            if (list_take) begin
                pend_entry_reg <= e_entry;
                if (pend_reg) begin
                    o_status_reg <= ST_OK;
                    o_entry_reg <= pend_entry_reg;
                    o_last_reg <= 1'b0;
                end
                if (scan_end && !pend_reg) begin
                    o_status_reg <= ST_OK;
                    o_entry_reg <= e_entry;
                    o_last_reg <= 1'b1;
                end
            end else if (scan_end) begin
                o_status_reg <= pend_reg ? ST_OK : e_status;
                o_entry_reg <= pend_reg ? pend_entry_reg : '0;
                o_last_reg <= 1'b1;
            end
        end else if (state_reg == S_EXEC && e_valid) begin
            o_status_reg <= e_status;
            o_entry_reg <= e_entry;
            o_last_reg <= e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tail_reg <= 1'b0;
        else if (list_take && scan_end && pend_reg)
            tail_reg <= 1'b1;
        else if (state_reg == S_OUT && !o_valid_reg && m_axis_tready)
            tail_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (list_take && scan_end && pend_reg)
            tail_entry_reg <= e_entry;
    end

    assign m_axis_tvalid = o_valid_reg || (state_reg == S_OUT && tail_reg && !o_valid_reg);
    assign m_axis_tuser = (o_valid_reg) ? o_status_reg : ST_OK;
    assign m_axis_tdata = o_valid_reg
        ? {o_entry_reg.alias_key[15:0], o_entry_reg.alias_key[79:16], o_entry_reg.address}
        : {tail_entry_reg.alias_key[15:0], tail_entry_reg.alias_key[79:16],
           tail_entry_reg.address};
    assign m_axis_tlast = o_valid_reg ? o_last_reg : 1'b1;
endmodule

/* rtl/core/iat_cell.sv */
// One table cell: holds an entry, compares it against the key, shifts.
// Depends on iat_pkg.
module iat_cell
    import iat_pkg::*;
(
    input  logic        clk,
    input  logic        shift_in,   // take the entry from the front neighbor
    input  logic        shift_out,  // take the entry from the back neighbor
    input  logic        load_key,   // take the key entry
    input  logic        load_addr,  // replace the address only
    input  entry_t      prev_entry,
    input  entry_t      next_entry,
    input  entry_t      key_entry,
    input  logic [79:0] key_fold,
    output entry_t      entry,
    output match_t      match
);
    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (load_key)
            entry_reg <= key_entry;
        else if (load_addr)
            entry_reg.address <= key_entry.address;
        else if (shift_in)
            entry_reg <= prev_entry;
        else if (shift_out)
            entry_reg <= next_entry;
    end

    assign entry = entry_reg;
    assign match.addr_eq = (entry_reg.address == key_entry.address);
    assign match.alias_eq = (fold_alias(entry_reg.alias_key) == key_fold);
    assign match.loc_eq = (entry_reg.address[31:16] == key_entry.address[31:16]);
endmodule
